[rtl/srec_pkg.sv]
// Shared types, constants and character helpers for the S2 record to word text converter.
// Used by the parser, queue, expander, top level and bench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package srec_pkg;

	localparam logic [7:0] CH_S    = 8'h53;
	localparam logic [7:0] CH_TWO  = 8'h32;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NL   = 8'h0a;
	localparam logic [2:0] ADDR_LAST = 3'd5;
	localparam logic [7:0] CNT_BIAS  = 8'd4;
	localparam logic [3:0] PREFIX_LEN = 4'd9;
	localparam int FIFO_DEPTH_DEF = 4;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_TYPE,
		PH_CNT_HI,
		PH_CNT_LO,
		PH_ADDR,
		PH_DATA,
		PH_END_OK,
		PH_END_ERR
	} phase_t;

	typedef enum logic [2:0] {
		OP_EMPTY,
		OP_CHAR,
		OP_PFX_CHAR,
		OP_CHAR_NL,
		OP_FILL
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
		logic       finished;
		logic       status;
	} cmd_t;

	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic [3:0] op_last_idx(input op_t op);
		logic [3:0] r;
		case (op)
			OP_PFX_CHAR: r = PREFIX_LEN;
			OP_CHAR_NL:  r = 4'd1;
			OP_FILL:     r = 4'd4;
			default:     r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0:    r = 8'h09;
			4'd1:    r = 8'h2e;
			4'd2:    r = 8'h77;
			4'd3:    r = 8'h6f;
			4'd4:    r = 8'h72;
			4'd5:    r = 8'h64;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h30;
			4'd8:    r = 8'h78;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/srec_in_if.sv]
// Input channel: one text character or an end marker per request.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface srec_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_input;

	modport source (output valid, output in_char, output end_of_input, input ready);
	modport sink (input valid, input in_char, input end_of_input, output ready);
endinterface
`default_nettype wire

[rtl/srec_out_if.sv]
// Output channel: one result item per request.
// Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface srec_out_if;
	logic       valid;
	logic       ready;
	logic       has_char;
	logic [7:0] out_char;
	logic       last;
	logic       finished;
	logic       status;

	modport source (output valid, output has_char, output out_char, output last,
		output finished, output status, input ready);
	modport sink (input valid, input has_char, input out_char, input last,
		input finished, input status, output ready);
endinterface
`default_nettype wire

[rtl/srec_front.sv]
// Front end: record parser that classifies each accepted character into one command.
// Depends on srec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srec_front import srec_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_char,
	input  wire logic       end_of_input,
	output logic            push_valid,
	input  wire logic       push_ready,
	output cmd_t            push_cmd
);

	phase_t     phase_q, phase_d;
	logic [3:0] cnt_hi_q, cnt_hi_d;
	logic [6:0] words_q, words_d;
	logic [1:0] cig_q, cig_d;
	logic [2:0] addr_q, addr_d;
	logic       pend_q, pend_d;
	logic [4:0] hex;
	logic [7:0] cnt;
	logic       done;
	logic       accept;

	assign hex      = hex_decode(in_char);
	assign cnt      = {cnt_hi_q, hex[3:0]};
	assign done     = (phase_q == PH_END_OK) || (phase_q == PH_END_ERR);
	assign in_ready = push_ready;
	assign accept   = in_valid && push_ready;

	always_comb begin
		phase_d  = phase_q;
		cnt_hi_d = cnt_hi_q;
		words_d  = words_q;
		cig_d    = cig_q;
		addr_d   = addr_q;
		pend_d   = pend_q;
		if (!done && end_of_input) begin
			phase_d = PH_END_ERR;
		end else if (!done) begin
			case (phase_q)
				PH_HUNT: begin
					if (in_char == CH_S) phase_d = PH_TYPE;
				end
				PH_TYPE: begin
					if (in_char == CH_TWO) begin
						phase_d = PH_CNT_HI;
					end else begin
						pend_d  = 1'b0;
						phase_d = PH_END_OK;
					end
				end
				PH_CNT_HI: begin
					if (!hex[4]) begin
						phase_d = PH_END_ERR;
					end else begin
						cnt_hi_d = hex[3:0];
						phase_d  = PH_CNT_LO;
					end
				end
				PH_CNT_LO: begin
					if (!hex[4]) begin
						phase_d = PH_END_ERR;
					end else begin
						words_d = (cnt >= CNT_BIAS) ? 7'((cnt - CNT_BIAS) >> 1) : 7'd0;
						addr_d  = 3'd0;
						phase_d = PH_ADDR;
					end
				end
				PH_ADDR: begin
					addr_d = addr_q + 3'd1;
					if (addr_q == ADDR_LAST) begin
						addr_d  = 3'd0;
						cig_d   = 2'd0;
						phase_d = (words_q != 7'd0) ? PH_DATA : PH_HUNT;
					end
				end
				PH_DATA: begin
					cig_d = cig_q + 2'd1;
					if (cig_q == 2'd3) begin
						pend_d = !pend_q;
						if (words_q != 7'd0) words_d = words_q - 7'd1;
						if (words_q <= 7'd1) phase_d = PH_HUNT;
					end
				end
				default: phase_d = phase_q;
			endcase
		end
	end

	always_comb begin
		push_cmd.op       = OP_EMPTY;
		push_cmd.ch       = in_char;
		push_cmd.finished = (phase_d == PH_END_OK) || (phase_d == PH_END_ERR);
		push_cmd.status   = (phase_d == PH_END_ERR);
		push_valid        = in_valid;
		if (!done && !end_of_input) begin
			case (phase_q)
				PH_TYPE: begin
					if (in_char != CH_TWO && pend_q) push_cmd.op = OP_FILL;
				end
				PH_DATA: begin
					if (cig_q == 2'd0 && !pend_q) begin
						push_cmd.op = OP_PFX_CHAR;
					end else if (cig_q == 2'd3 && pend_q) begin
						push_cmd.op = OP_CHAR_NL;
					end else begin
						push_cmd.op = OP_CHAR;
					end
				end
				default: push_cmd.op = OP_EMPTY;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			cnt_hi_q <= 4'd0;
			words_q  <= 7'd0;
			cig_q    <= 2'd0;
			addr_q   <= 3'd0;
			pend_q   <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			cnt_hi_q <= cnt_hi_d;
			words_q  <= words_d;
			cig_q    <= cig_d;
			addr_q   <= addr_d;
			pend_q   <= pend_d;
		end
	end

endmodule
`default_nettype wire

[rtl/srec_fifo.sv]
// Short command queue between the parser and the character expander.
// Depends on srec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srec_fifo import srec_pkg::*; #(
	parameter int DEPTH = FIFO_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  wire cmd_t push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_ready && pop_valid;
	assign pop_cmd    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			if (push && !pop) cnt_q <= cnt_q + CW'(1);
			else if (pop && !push) cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule
`default_nettype wire

[rtl/srec_back.sv]
// Back end: expands each queued command into result items through an output register.
// Depends on srec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module srec_back import srec_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output logic      pop_ready,
	input  wire cmd_t pop_cmd,
	srec_out_if.source lines
);

	logic [3:0] idx_q;
	logic       ov_q;
	logic       load, take, at_last;
	logic [7:0] ch;

	assign load    = !ov_q || lines.ready;
	assign take    = load && pop_valid;
	assign at_last = (idx_q == op_last_idx(pop_cmd.op));
	assign pop_ready = take && at_last;

	always_comb begin
		case (pop_cmd.op)
			OP_CHAR:     ch = pop_cmd.ch;
			OP_PFX_CHAR: ch = (idx_q < PREFIX_LEN) ? prefix_char(idx_q) : pop_cmd.ch;
			OP_CHAR_NL:  ch = (idx_q == 4'd0) ? pop_cmd.ch : CH_NL;
			OP_FILL:     ch = (idx_q == 4'd4) ? CH_NL : CH_ZERO;
			default:     ch = 8'h00;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= 4'd0;
		end else if (take) begin
			ov_q  <= 1'b1;
			idx_q <= at_last ? 4'd0 : idx_q + 4'd1;
		end else if (load) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			lines.has_char <= (pop_cmd.op != OP_EMPTY);
			lines.out_char <= ch;
			lines.last     <= at_last;
			lines.finished <= pop_cmd.finished;
			lines.status   <= pop_cmd.status;
		end
	end

	assign lines.valid = ov_q;

endmodule
`default_nettype wire

[rtl/srec_s2_to_word_text.sv]
// Top level of the S2 record to word text converter: parser, command queue, expander.
// Depends on srec_pkg, srec_in_if, srec_out_if, srec_front, srec_fifo, srec_back.
//
// The text channel takes one character per request, or an end marker. Each request
// gives one or more result requests on the lines channel, the final one marked by last.
// A character that emits nothing gives one result with has_char low; every result
// carries finished and status as they stand after its character.
// The parser accepts one character per cycle while the command queue has room.
// The first result of a character passes the command queue and then the output register. The
// expander sends one result per cycle while the receiver is ready and the queue is not empty;
// a character gives one result for most, two where a line closes, five for the fill,
// ten where a line opens; the output side sets the sustained rate.
// Reset empties the queue and the output register and returns the parser to hunting.
// When the receiver stalls the output register holds its result, the queue fills and
// then the text channel drops ready. After the end, characters are still accepted
// and each gives one empty result.
`timescale 1ns / 1ps
`default_nettype none
module srec_s2_to_word_text import srec_pkg::*; #(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	srec_in_if.sink    text,
	srec_out_if.source lines
);

	logic push_valid, push_ready, pop_valid, pop_ready;
	cmd_t push_cmd, pop_cmd;

	srec_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (text.valid),
		.in_ready     (text.ready),
		.in_char      (text.in_char),
		.end_of_input (text.end_of_input),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	srec_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	srec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd),
		.lines     (lines)
	);

endmodule
`default_nettype wire

[rtl/srec_checker.sv]
// Port-level checks for the converter, attached to the top level by bind.
// Depends on the top level srec_s2_to_word_text.
`timescale 1ns / 1ps
`default_nettype none
module srec_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       has_char,
	input wire logic [7:0] out_char,
	input wire logic       last,
	input wire logic       finished,
	input wire logic       status
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last))
		else $error("stalled result changed");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char |-> last && (out_char == 8'h00))
		else $error("empty result not alone or not zero");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> finished)
		else $error("error status without finished");

	a_fin_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && finished && status |=> !out_valid || !has_char)
		else $error("character emitted after error end");

endmodule

bind srec_s2_to_word_text srec_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (lines.valid),
	.out_ready (lines.ready),
	.has_char  (lines.has_char),
	.out_char  (lines.out_char),
	.last      (lines.last),
	.finished  (lines.finished),
	.status    (lines.status)
);
`default_nettype wire

[tb/srec_s2_to_word_text_test.sv]
// Self-checking bench for srec_s2_to_word_text: feeds S2 record text with random pacing
// and checks every emitted word-text result against a scoreboard predictor.
// Depends on srec_pkg, srec_in_if, srec_out_if and the converter itself.
`timescale 1ns / 1ps
module srec_s2_to_word_text_test;
	import srec_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 370;
	localparam logic [71:0] WORD_PREFIX = {8'h09, ".word 0x"};

	typedef struct packed {
		logic       has_char;
		logic [7:0] out_char;
		logic       last;
		logic       finished;
		logic       status;
	} line_item_t;

	class word_line_scoreboard;
		phase_t     ph;
		logic [3:0] count_hi;
		logic [6:0] groups_left;
		logic [1:0] group_pos;
		logic [2:0] addr_pos;
		logic       half_line;
		logic       ended;
		line_item_t due_results[$];
		int         errors;

		function new();
			ph = PH_HUNT;
			count_hi = '0;
			groups_left = '0;
			group_pos = '0;
			addr_pos = '0;
			half_line = 1'b0;
			ended = 1'b0;
			errors = 0;
		endfunction

		static function int nibble_of(logic [7:0] c);
			if (c >= "0" && c <= "9") return int'(c - "0");
			if (c >= "a" && c <= "f") return int'(c - "a") + 10;
			if (c >= "A" && c <= "F") return int'(c - "A") + 10;
			return -1;
		endfunction

		function void take_char(logic [7:0] c, logic eoi);
			logic [7:0] emitted[$];
			logic [7:0] count;
			line_item_t item;
			int v;
			int n;
			emitted = {};
			if (!ended) begin
				if (eoi) begin
					ph = PH_END_ERR;
					ended = 1'b1;
				end else begin
					case (ph)
						PH_HUNT: begin
							if (c == CH_S) ph = PH_TYPE;
						end
						PH_TYPE: begin
							if (c == CH_TWO) begin
								ph = PH_CNT_HI;
							end else begin
								if (half_line) begin
									emitted = {CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_NL};
									half_line = 1'b0;
								end
								ph = PH_END_OK;
								ended = 1'b1;
							end
						end
						PH_CNT_HI: begin
							v = nibble_of(c);
							if (v < 0) begin
								ph = PH_END_ERR;
								ended = 1'b1;
							end else begin
								count_hi = 4'(v);
								ph = PH_CNT_LO;
							end
						end
						PH_CNT_LO: begin
							v = nibble_of(c);
							if (v < 0) begin
								ph = PH_END_ERR;
								ended = 1'b1;
							end else begin
								count = {count_hi, 4'(v)};
								groups_left = (count >= CNT_BIAS) ? 7'((count - CNT_BIAS) >> 1) : '0;
								addr_pos = '0;
								ph = PH_ADDR;
							end
						end
						PH_ADDR: begin
							addr_pos = addr_pos + 3'd1;
							if (addr_pos >= 3'd6) begin
								addr_pos = '0;
								group_pos = '0;
								ph = (groups_left != 0) ? PH_DATA : PH_HUNT;
							end
						end
						PH_DATA: begin
							if (group_pos == 0 && !half_line) begin
								for (int i = 0; i < 9; i++) emitted.push_back(WORD_PREFIX[71 - 8 * i -: 8]);
							end
							emitted.push_back(c);
							group_pos = group_pos + 2'd1;
							if (group_pos == 0) begin
								if (half_line) emitted.push_back(CH_NL);
								half_line = !half_line;
								if (groups_left != 0) groups_left = groups_left - 7'd1;
								if (groups_left == 0) ph = PH_HUNT;
							end
						end
						default: ph = PH_HUNT;
					endcase
				end
			end
			n = (emitted.size() > 0) ? emitted.size() : 1;
			for (int k = 0; k < n; k++) begin
				item.has_char = (k < emitted.size());
				item.out_char = (k < emitted.size()) ? emitted[k] : 8'h00;
				item.last = (k == n - 1);
				item.finished = ended;
				item.status = ended && (ph == PH_END_ERR);
				due_results.push_back(item);
			end
		endfunction

		function void match_output(line_item_t got);
			line_item_t want;
			if (due_results.size() == 0) begin
				$error("unexpected result: out_char %0h has_char %0h", got.out_char, got.has_char);
				errors++;
				return;
			end
			want = due_results.pop_front();
			if (got.has_char !== want.has_char) begin
				$error("has_char expected %0h got %0h", want.has_char, got.has_char);
				errors++;
			end
			if (got.out_char !== want.out_char) begin
				$error("out_char expected %0h got %0h", want.out_char, got.out_char);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last expected %0h got %0h", want.last, got.last);
				errors++;
			end
			if (got.finished !== want.finished) begin
				$error("finished expected %0h got %0h", want.finished, got.finished);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status expected %0h got %0h", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int sent = 0;
	int cycle_count = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;
	bit hold_next = 1'b0;
	bit held_once = 1'b0;
	word_line_scoreboard board = new();

	srec_in_if text_ch();
	srec_out_if lines_ch();

	srec_s2_to_word_text dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.lines(lines_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] hex_char(logic [3:0] v);
		if (v < 4'd10) return CH_ZERO + 8'(v);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
	endfunction

	task automatic push_char(input logic [7:0] c, input logic eoi);
		int gap;
		if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 18);
		if (hold_next) begin
			text_ch.valid <= 1'b0;
			do @(posedge clk); while (board.due_results.size() != 0);
			hold_next = 1'b0;
		end else if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.in_char <= c;
		text_ch.end_of_input <= eoi;
		@(negedge clk);
		while (!text_ch.ready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		board.take_char(c, eoi);
		sent++;
	endtask

	task automatic send_record(input logic [7:0] count, input bit with_sum);
		int data_chars;
		data_chars = (count >= CNT_BIAS) ? ((count - CNT_BIAS) >> 1) * 4 : 0;
		push_char(CH_S, 1'b0);
		push_char(CH_TWO, 1'b0);
		push_char(hex_char(count[7:4]), 1'b0);
		push_char(hex_char(count[3:0]), 1'b0);
		repeat (6 + data_chars) push_char(8'($urandom_range(0, 255)), 1'b0);
		if (with_sum) repeat (2) push_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
	endtask

	initial begin : receiver
		line_item_t got;
		int gap;
		lines_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
			gap = rx_calm ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				lines_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			lines_ch.ready <= 1'b1;
			@(negedge clk);
			while (!lines_ch.valid) begin
				@(posedge clk);
				@(negedge clk);
			end
			got.has_char = lines_ch.has_char;
			got.out_char = lines_ch.out_char;
			got.last = lines_ch.last;
			got.finished = lines_ch.finished;
			got.status = lines_ch.status;
			@(posedge clk);
			board.match_output(got);
		end
	end

	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("srec_s2_to_word_text_test: errors");
		$finish;
	end

	initial begin : stimulus
		logic [7:0] c;
		logic [7:0] count;
		int r;
		int kind;
		int cut;
		text_ch.valid <= 1'b0;
		text_ch.in_char <= 8'h00;
		text_ch.end_of_input <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Hunting skips both byte extremes; then one data group and a record too short for data.
		push_char(8'h00, 1'b0);
		push_char(8'hff, 1'b0);
		send_record(8'h06, 1'b0);
		send_record(8'h03, 1'b0);

		while (sent < RANDOM_ITEMS) begin
			repeat ($urandom_range(0, 3)) begin
				do c = 8'($urandom_range(0, 255)); while (c == CH_S);
				push_char(c, 1'b0);
			end
			r = $urandom_range(0, 99);
			if (r < 10) count = 8'($urandom_range(0, 3));
			else if (r < 85) count = 8'($urandom_range(4, 31));
			else count = 8'($urandom_range(32, 63));
			send_record(count, 1'b1);
			if (!held_once && sent > RANDOM_ITEMS / 2) begin
				hold_next = 1'b1;
				held_once = 1'b1;
			end
		end

		kind = $urandom_range(0, 2);
		case (kind)
			0: begin
				push_char(CH_S, 1'b0);
				do c = 8'($urandom_range(0, 255)); while (c == CH_TWO);
				push_char(c, 1'b0);
			end
			1: begin
				cut = $urandom_range(0, 17);
				for (int i = 0; i < cut; i++) begin
					case (i)
						0: c = CH_S;
						1: c = CH_TWO;
						2: c = CH_ZERO;
						3: c = 8'h38;
						default: c = 8'($urandom_range(0, 255));
					endcase
					push_char(c, 1'b0);
				end
				push_char(8'($urandom_range(0, 255)), 1'b1);
			end
			default: begin
				push_char(CH_S, 1'b0);
				push_char(CH_TWO, 1'b0);
				if ($urandom_range(0, 1)) push_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
				do c = 8'($urandom_range(0, 255)); while (word_line_scoreboard::nibble_of(c) >= 0);
				push_char(c, 1'b0);
			end
		endcase

		push_char(8'($urandom_range(0, 255)), 1'b1);
		repeat ($urandom_range(3, 8)) push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		text_ch.valid <= 1'b0;

		while (board.due_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.errors == 0) begin
			$display("srec_s2_to_word_text_test: clean");
		end else begin
			$display("srec_s2_to_word_text_test: errors");
		end
		$finish;
	end
endmodule
